FILE: rtl/xsd_dur_pkg.sv
package xsd_dur_pkg;

	// Field widths of the channels and the configuration register.
	localparam int unsigned TEXT_W   = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SEC_W    = 63;
	localparam int unsigned LEN_W    = 13;
	localparam int unsigned MULT_W   = 17;
	localparam int unsigned PROD_W   = SEC_W + MULT_W;

	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 13'd256;

	// Seconds per component unit.
	localparam logic [MULT_W-1:0] MULT_DAY    = 17'd86400;
	localparam logic [MULT_W-1:0] MULT_HOUR   = 17'd3600;
	localparam logic [MULT_W-1:0] MULT_MINUTE = 17'd60;
	localparam logic [MULT_W-1:0] MULT_SECOND = 17'd1;

	// ASCII codes the grammar looks at.
	localparam logic [TEXT_W-1:0] CH_P     = 8'h50;
	localparam logic [TEXT_W-1:0] CH_T     = 8'h54;
	localparam logic [TEXT_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [TEXT_W-1:0] CH_Y     = 8'h59;
	localparam logic [TEXT_W-1:0] CH_M     = 8'h4D;
	localparam logic [TEXT_W-1:0] CH_D     = 8'h44;
	localparam logic [TEXT_W-1:0] CH_H     = 8'h48;
	localparam logic [TEXT_W-1:0] CH_S     = 8'h53;
	localparam logic [TEXT_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [TEXT_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [TEXT_W-1:0] CH_NINE  = 8'h39;

	// Designator order inside the date part and inside the time part.
	localparam logic [1:0] STG_NONE   = 2'd0;
	localparam logic [1:0] STG_FIRST  = 2'd1;
	localparam logic [1:0] STG_SECOND = 2'd2;
	localparam logic [1:0] STG_THIRD  = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		STAT_FIXED     = 3'd0,
		STAT_PRESERVE  = 3'd1,
		STAT_MALFORMED = 3'd2,
		STAT_NEGATIVE  = 3'd3,
		STAT_OVERSIZED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_EXPECT_P = 2'd0,
		PH_DATE     = 2'd1,
		PH_TIME     = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_MALFORMED = 2'd1,
		ERR_NEGATIVE  = 2'd2
	} err_t;

	// Work handed from the parser to the accumulator for one beat.
	typedef struct packed {
		logic              commit;
		logic              comp_ovf;
		logic [PROD_W-1:0] prod;
		logic              last;
		status_t           status;
	} acc_op_t;

endpackage

FILE: rtl/xsd_dur_if.sv
// Input channel: one text byte per beat.
interface xsd_dur_in_if;
	logic                              valid;
	logic                              ready;
	logic [xsd_dur_pkg::TEXT_W-1:0]    text_byte;
	logic                              is_last;

	modport source (output valid, output text_byte, output is_last, input ready);
	modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

// Output channel: one result per text.
interface xsd_dur_out_if;
	logic                              valid;
	logic                              ready;
	logic [xsd_dur_pkg::STATUS_W-1:0]  status;
	logic [xsd_dur_pkg::SEC_W-1:0]     seconds;

	modport source (output valid, output status, output seconds, input ready);
	modport sink   (input valid, input status, input seconds, output ready);
endinterface

FILE: rtl/xsd_duration_to_seconds.sv
// Channel   Dir  Payload                 Beat
// in_ch     in   text_byte, is_last      one byte of duration text
// out_ch    out  status, seconds         one result after the last byte
// cfg       in   cfg_wr_data (13 bits)   max_length write when cfg_wr_en
//
// One byte is taken every cycle while in_ch.ready is high. The parser updates
// its state in the accept cycle and registers the component product; the
// accumulator adds it to the total, and the result register takes the result.
// Reset clears all text state and sets max_length to 256.
// Only a stalled result with a further last byte behind it holds the input.
module xsd_duration_to_seconds (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [xsd_dur_pkg::LEN_W-1:0]      cfg_wr_data,
	xsd_dur_in_if.sink                         in_ch,
	xsd_dur_out_if.source                      out_ch
);

	localparam int unsigned SEC_W  = xsd_dur_pkg::SEC_W;
	localparam int unsigned PROD_W = xsd_dur_pkg::PROD_W;
	localparam int unsigned LEN_W  = xsd_dur_pkg::LEN_W;

	// Configuration register.
	logic [LEN_W-1:0] max_length_q;

	// Parser state.
	logic [LEN_W-1:0]         byte_count_q, n_byte_count;
	logic                     too_long_q, n_too_long;
	xsd_dur_pkg::phase_t      phase_q, n_phase;
	logic [1:0]               prior_q, n_prior;
	logic                     dpend_q, n_dpend;
	logic                     frac_q, n_frac;
	logic                     frac_seen_q, n_frac_seen;
	logic [SEC_W-1:0]         comp_q, n_comp;
	logic                     comp_ovf_q, n_comp_ovf;
	logic                     comp_nz_q, n_comp_nz;
	logic                     preserve_q, n_preserve;
	logic                     date_seen_q, n_date_seen;
	logic                     time_seen_q, n_time_seen;
	xsd_dur_pkg::err_t        err_q, n_err;

	// Parser work signals.
	logic [xsd_dur_pkg::TEXT_W-1:0] c;
	logic                           is_digit;
	logic [3:0]                     digit;
	logic [SEC_W+3:0]               times_ten;
	logic                           ok;
	logic [1:0]                     stg;
	logic                           cmt;
	logic [xsd_dur_pkg::MULT_W-1:0] cmt_mult;
	logic                           bad_shape;
	xsd_dur_pkg::status_t           pre_status;

	// Handshake and pipeline.
	logic                   accept;
	logic                   s1_move;
	logic                   op_valid_s1;
	xsd_dur_pkg::acc_op_t   op_s1;

	// Accumulator and result register.
	logic [SEC_W-1:0]       total_q;
	logic                   tot_ovf_q;
	logic [SEC_W:0]         sum;
	logic                   add_ovf;
	logic [SEC_W-1:0]       n_total;
	logic                   n_tot_ovf;
	logic                   out_valid_q;
	xsd_dur_pkg::status_t   out_status_q;
	logic [SEC_W-1:0]       out_seconds_q;
	xsd_dur_pkg::status_t   fin_status;

	// The pipeline register moves unless it holds a last beat and the result
	// register is still full.
	assign s1_move     = op_valid_s1 && !(op_s1.last && out_valid_q && !out_ch.ready);
	assign in_ch.ready = !op_valid_s1 || s1_move;
	assign accept      = in_ch.valid && in_ch.ready;

	assign out_ch.valid   = out_valid_q;
	assign out_ch.status  = out_status_q;
	assign out_ch.seconds = out_seconds_q;

	// Configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= xsd_dur_pkg::MAX_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			max_length_q <= cfg_wr_data;
		end
	end

	// Byte decode and the next decimal step of the component.
	assign c         = in_ch.text_byte;
	assign is_digit  = (c >= xsd_dur_pkg::CH_ZERO) && (c <= xsd_dur_pkg::CH_NINE);
	assign digit     = c[3:0];
	assign times_ten = ({4'b0, comp_q} << 3) + ({4'b0, comp_q} << 1)
	                   + {{SEC_W{1'b0}}, digit};

	// Grammar: next parser state for the current byte.
	always_comb begin
		n_byte_count = byte_count_q;
		n_too_long   = too_long_q;
		n_phase      = phase_q;
		n_prior      = prior_q;
		n_dpend      = dpend_q;
		n_frac       = frac_q;
		n_frac_seen  = frac_seen_q;
		n_comp       = comp_q;
		n_comp_ovf   = comp_ovf_q;
		n_comp_nz    = comp_nz_q;
		n_preserve   = preserve_q;
		n_date_seen  = date_seen_q;
		n_time_seen  = time_seen_q;
		n_err        = err_q;
		ok           = 1'b1;
		stg          = xsd_dur_pkg::STG_NONE;
		cmt          = 1'b0;
		cmt_mult     = xsd_dur_pkg::MULT_SECOND;

		if (byte_count_q >= max_length_q) begin
			n_too_long = 1'b1;
		end else begin
			n_byte_count = byte_count_q + 1'b1;
		end

		if (err_q == xsd_dur_pkg::ERR_NONE) begin
			case (phase_q)
				xsd_dur_pkg::PH_EXPECT_P: begin
					if (c == xsd_dur_pkg::CH_MINUS) begin
						n_err = xsd_dur_pkg::ERR_NEGATIVE;
					end else if (c != xsd_dur_pkg::CH_P) begin
						n_err = xsd_dur_pkg::ERR_MALFORMED;
					end else begin
						n_phase = xsd_dur_pkg::PH_DATE;
					end
				end
				xsd_dur_pkg::PH_DATE: begin
					if (is_digit) begin
						n_dpend = 1'b1;
					end else if (!dpend_q) begin
						if (c == xsd_dur_pkg::CH_T) begin
							n_phase = xsd_dur_pkg::PH_TIME;
							n_prior = xsd_dur_pkg::STG_NONE;
						end else begin
							ok = 1'b0;
						end
					end else if (c == xsd_dur_pkg::CH_Y || c == xsd_dur_pkg::CH_M ||
					             c == xsd_dur_pkg::CH_D) begin
						if (c == xsd_dur_pkg::CH_Y) begin
							stg = xsd_dur_pkg::STG_FIRST;
						end else if (c == xsd_dur_pkg::CH_M) begin
							stg = xsd_dur_pkg::STG_SECOND;
						end else begin
							stg = xsd_dur_pkg::STG_THIRD;
						end
						if (stg <= prior_q) begin
							ok = 1'b0;
						end else begin
							n_prior = stg;
						end
						if (c == xsd_dur_pkg::CH_D) begin
							cmt      = 1'b1;
							cmt_mult = xsd_dur_pkg::MULT_DAY;
						end else if (comp_nz_q) begin
							n_preserve = 1'b1;
						end
						n_date_seen = 1'b1;
						n_dpend     = 1'b0;
						n_comp      = '0;
						n_comp_ovf  = 1'b0;
						n_comp_nz   = 1'b0;
					end else begin
						ok = 1'b0;
					end
				end
				xsd_dur_pkg::PH_TIME: begin
					if (frac_q) begin
						if (is_digit) begin
							n_frac_seen = 1'b1;
							if (c != xsd_dur_pkg::CH_ZERO) begin
								n_preserve = 1'b1;
							end
						end else if (c == xsd_dur_pkg::CH_S && frac_seen_q) begin
							n_frac      = 1'b0;
							n_frac_seen = 1'b0;
							n_prior     = xsd_dur_pkg::STG_THIRD;
							n_time_seen = 1'b1;
						end else begin
							ok = 1'b0;
						end
					end else if (is_digit) begin
						n_dpend = 1'b1;
					end else if (!dpend_q) begin
						ok = 1'b0;
					end else if (c == xsd_dur_pkg::CH_DOT) begin
						if (prior_q >= xsd_dur_pkg::STG_THIRD) begin
							ok = 1'b0;
						end else begin
							cmt         = 1'b1;
							cmt_mult    = xsd_dur_pkg::MULT_SECOND;
							n_dpend     = 1'b0;
							n_comp      = '0;
							n_comp_ovf  = 1'b0;
							n_comp_nz   = 1'b0;
							n_frac      = 1'b1;
							n_frac_seen = 1'b0;
						end
					end else if (c == xsd_dur_pkg::CH_H || c == xsd_dur_pkg::CH_M ||
					             c == xsd_dur_pkg::CH_S) begin
						if (c == xsd_dur_pkg::CH_H) begin
							stg      = xsd_dur_pkg::STG_FIRST;
							cmt_mult = xsd_dur_pkg::MULT_HOUR;
						end else if (c == xsd_dur_pkg::CH_M) begin
							stg      = xsd_dur_pkg::STG_SECOND;
							cmt_mult = xsd_dur_pkg::MULT_MINUTE;
						end else begin
							stg      = xsd_dur_pkg::STG_THIRD;
							cmt_mult = xsd_dur_pkg::MULT_SECOND;
						end
						if (stg <= prior_q) begin
							ok = 1'b0;
						end else begin
							n_prior = stg;
						end
						cmt         = 1'b1;
						n_time_seen = 1'b1;
						n_dpend     = 1'b0;
						n_comp      = '0;
						n_comp_ovf  = 1'b0;
						n_comp_nz   = 1'b0;
					end else begin
						ok = 1'b0;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase

			// A digit outside a fraction extends the component.
			if (is_digit && phase_q != xsd_dur_pkg::PH_EXPECT_P && !frac_q) begin
				if (digit != 4'd0) begin
					n_comp_nz = 1'b1;
				end
				if (!comp_ovf_q) begin
					if (times_ten[SEC_W+3:SEC_W] != 4'd0) begin
						n_comp_ovf = 1'b1;
					end else begin
						n_comp = times_ten[SEC_W-1:0];
					end
				end
			end

			if (!ok) begin
				n_err = xsd_dur_pkg::ERR_MALFORMED;
			end
		end
	end

	// Status known at the last byte; a fixed result still awaits the total.
	always_comb begin
		bad_shape = (n_err == xsd_dur_pkg::ERR_MALFORMED)
		            || (n_phase != xsd_dur_pkg::PH_TIME && n_phase != xsd_dur_pkg::PH_DATE)
		            || n_dpend || n_frac
		            || (n_phase == xsd_dur_pkg::PH_TIME && !n_time_seen)
		            || (!n_date_seen && !n_time_seen);
		if (n_too_long) begin
			pre_status = xsd_dur_pkg::STAT_OVERSIZED;
		end else if (n_err == xsd_dur_pkg::ERR_NEGATIVE) begin
			pre_status = xsd_dur_pkg::STAT_NEGATIVE;
		end else if (bad_shape) begin
			pre_status = xsd_dur_pkg::STAT_MALFORMED;
		end else if (n_preserve) begin
			pre_status = xsd_dur_pkg::STAT_PRESERVE;
		end else begin
			pre_status = xsd_dur_pkg::STAT_FIXED;
		end
	end

	// Parser state registers; a last beat returns them to the start of a text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			too_long_q   <= 1'b0;
			phase_q      <= xsd_dur_pkg::PH_EXPECT_P;
			prior_q      <= xsd_dur_pkg::STG_NONE;
			dpend_q      <= 1'b0;
			frac_q       <= 1'b0;
			frac_seen_q  <= 1'b0;
			comp_q       <= '0;
			comp_ovf_q   <= 1'b0;
			comp_nz_q    <= 1'b0;
			preserve_q   <= 1'b0;
			date_seen_q  <= 1'b0;
			time_seen_q  <= 1'b0;
			err_q        <= xsd_dur_pkg::ERR_NONE;
		end else if (accept) begin
			if (in_ch.is_last) begin
				byte_count_q <= '0;
				too_long_q   <= 1'b0;
				phase_q      <= xsd_dur_pkg::PH_EXPECT_P;
				prior_q      <= xsd_dur_pkg::STG_NONE;
				dpend_q      <= 1'b0;
				frac_q       <= 1'b0;
				frac_seen_q  <= 1'b0;
				comp_q       <= '0;
				comp_ovf_q   <= 1'b0;
				comp_nz_q    <= 1'b0;
				preserve_q   <= 1'b0;
				date_seen_q  <= 1'b0;
				time_seen_q  <= 1'b0;
				err_q        <= xsd_dur_pkg::ERR_NONE;
			end else begin
				byte_count_q <= n_byte_count;
				too_long_q   <= n_too_long;
				phase_q      <= n_phase;
				prior_q      <= n_prior;
				dpend_q      <= n_dpend;
				frac_q       <= n_frac;
				frac_seen_q  <= n_frac_seen;
				comp_q       <= n_comp;
				comp_ovf_q   <= n_comp_ovf;
				comp_nz_q    <= n_comp_nz;
				preserve_q   <= n_preserve;
				date_seen_q  <= n_date_seen;
				time_seen_q  <= n_time_seen;
				err_q        <= n_err;
			end
		end
	end

	// Pipeline register: component product and result class for the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
		end else if (accept) begin
			op_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			op_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1.commit   <= cmt && (err_q == xsd_dur_pkg::ERR_NONE);
			op_s1.comp_ovf <= comp_ovf_q;
			op_s1.prod     <= PROD_W'(comp_q) * PROD_W'(cmt_mult);
			op_s1.last     <= in_ch.is_last;
			op_s1.status   <= pre_status;
		end
	end

	// Add of the product into the running total; an overflow sets a sticky flag.
	always_comb begin
		sum       = {1'b0, total_q} + {1'b0, op_s1.prod[SEC_W-1:0]};
		add_ovf   = op_s1.comp_ovf || (op_s1.prod[PROD_W-1:SEC_W] != '0) || sum[SEC_W];
		n_total   = total_q;
		n_tot_ovf = tot_ovf_q;
		if (op_s1.commit && !tot_ovf_q) begin
			if (add_ovf) begin
				n_tot_ovf = 1'b1;
			end else begin
				n_total = sum[SEC_W-1:0];
			end
		end
		if (op_s1.status == xsd_dur_pkg::STAT_FIXED && n_tot_ovf) begin
			fin_status = xsd_dur_pkg::STAT_OVERSIZED;
		end else begin
			fin_status = op_s1.status;
		end
	end

	// Accumulator registers, cleared after the last beat of a text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			tot_ovf_q <= 1'b0;
		end else if (s1_move) begin
			if (op_s1.last) begin
				total_q   <= '0;
				tot_ovf_q <= 1'b0;
			end else begin
				total_q   <= n_total;
				tot_ovf_q <= n_tot_ovf;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move && op_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && op_s1.last) begin
			out_status_q  <= fin_status;
			out_seconds_q <= (fin_status == xsd_dur_pkg::STAT_FIXED) ? n_total : '0;
		end
	end

endmodule
